// ===== hw/rtl/aalu_pkg.sv =====
// Shared types, op codes and flag positions for the AVR-style ALU block.
package aalu_pkg;

	// Register file geometry: even and odd registers sit in separate banks
	localparam int unsigned NUM_REGS   = 32;
	localparam int unsigned REG_IDX_W  = $clog2(NUM_REGS);
	localparam int unsigned BANK_DEPTH = NUM_REGS / 2;
	localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

	// Status register bit positions
	localparam int unsigned FLAG_C = 0;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_V = 3;
	localparam int unsigned FLAG_S = 4;
	localparam int unsigned FLAG_T = 6;

	// Operation codes
	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_ADC  = 5'd1;
	localparam logic [4:0] OP_SUB  = 5'd2;
	localparam logic [4:0] OP_SBC  = 5'd3;
	localparam logic [4:0] OP_AND  = 5'd4;
	localparam logic [4:0] OP_OR   = 5'd5;
	localparam logic [4:0] OP_EOR  = 5'd6;
	localparam logic [4:0] OP_CP   = 5'd7;
	localparam logic [4:0] OP_CPC  = 5'd8;
	localparam logic [4:0] OP_COM  = 5'd9;
	localparam logic [4:0] OP_NEG  = 5'd10;
	localparam logic [4:0] OP_INC  = 5'd11;
	localparam logic [4:0] OP_DEC  = 5'd12;
	localparam logic [4:0] OP_LSR  = 5'd13;
	localparam logic [4:0] OP_ASR  = 5'd14;
	localparam logic [4:0] OP_ROR  = 5'd15;
	localparam logic [4:0] OP_LSL  = 5'd16;
	localparam logic [4:0] OP_ROL  = 5'd17;
	localparam logic [4:0] OP_SWAP = 5'd18;
	localparam logic [4:0] OP_MOV  = 5'd19;
	localparam logic [4:0] OP_MOVW = 5'd20;
	localparam logic [4:0] OP_LDI  = 5'd21;
	localparam logic [4:0] OP_ADIW = 5'd22;
	localparam logic [4:0] OP_SBIW = 5'd23;
	localparam logic [4:0] OP_BSET = 5'd24;
	localparam logic [4:0] OP_BCLR = 5'd25;
	localparam logic [4:0] OP_BLD  = 5'd26;
	localparam logic [4:0] OP_BST  = 5'd27;
	localparam logic [4:0] OP_TST  = 5'd28;

	typedef struct packed {
		logic [4:0] op;
		logic [4:0] dest_index;
		logic [4:0] src_index;
		logic       use_immediate;
		logic [7:0] immediate;
		logic [2:0] bit_index;
	} cmd_t;

	typedef struct packed {
		logic [7:0] result;
		logic [7:0] result_high;
		logic [7:0] status;
	} rsp_t;

	typedef struct packed {
		logic               en;
		logic [BANK_AW-1:0] addr;
		logic [7:0]         data;
	} bank_wr_t;

	typedef struct packed {
		rsp_t     rsp;
		bank_wr_t even_wr;
		bank_wr_t odd_wr;
	} exec_t;

endpackage

// ===== hw/rtl/aalu_if.sv =====
// Valid/ready channel interfaces for the ALU instruction and result items.
interface aalu_cmd_if;
	logic       valid;
	logic       ready;
	logic [4:0] op;
	logic [4:0] dest_index;
	logic [4:0] src_index;
	logic       use_immediate;
	logic [7:0] immediate;
	logic [2:0] bit_index;

	modport source (
		output valid, op, dest_index, src_index, use_immediate, immediate, bit_index,
		input  ready
	);
	modport sink (
		input  valid, op, dest_index, src_index, use_immediate, immediate, bit_index,
		output ready
	);
endinterface

interface aalu_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic [7:0] result_high;
	logic [7:0] status;

	modport source (
		output valid, result, result_high, status,
		input  ready
	);
	modport sink (
		input  valid, result, result_high, status,
		output ready
	);
endinterface

// ===== hw/rtl/aalu_bank.sv =====
// One register file bank: two registered read ports, one write port, write-first.
module aalu_bank (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [aalu_pkg::BANK_AW-1:0]      rd_addr_a,
	input  logic [aalu_pkg::BANK_AW-1:0]      rd_addr_b,
	input  aalu_pkg::bank_wr_t                wr,
	output logic [7:0]                        rd_data_a,
	output logic [7:0]                        rd_data_b
);

	logic [7:0]                        mem_q [aalu_pkg::BANK_DEPTH];
	logic [aalu_pkg::BANK_DEPTH-1:0]   valid_q;
	logic [7:0]                        rd_a_q;
	logic [7:0]                        rd_b_q;

	// Write the array
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Track written entries; unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Read both ports, forward a same-edge write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && wr.addr == rd_addr_a) begin
				rd_a_q <= wr.data;
			end else if (valid_q[rd_addr_a]) begin
				rd_a_q <= mem_q[rd_addr_a];
			end else begin
				rd_a_q <= 8'h00;
			end
			if (wr.en && wr.addr == rd_addr_b) begin
				rd_b_q <= wr.data;
			end else if (valid_q[rd_addr_b]) begin
				rd_b_q <= mem_q[rd_addr_b];
			end else begin
				rd_b_q <= 8'h00;
			end
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ===== hw/rtl/aalu_exec.sv =====
// Execute stage: operand select, ALU, status update and write-back plan.
module aalu_exec (
	input  aalu_pkg::cmd_t  item,
	input  logic [7:0]      even_a,
	input  logic [7:0]      even_b,
	input  logic [7:0]      odd_a,
	input  logic [7:0]      odd_b,
	input  logic [7:0]      sreg,
	output aalu_pkg::exec_t exec
);

	logic [7:0]  a;
	logic [7:0]  src_reg;
	logic [7:0]  src;
	logic        cin;
	logic        add_cin;
	logic        sub_cin;
	logic [7:0]  add_r;
	logic [7:0]  sub_r;
	logic        add_c;
	logic        add_v;
	logic        sub_c;
	logic        sub_v;
	logic [15:0] word_in;
	logic [15:0] word_k;
	logic [15:0] word_r;
	logic [7:0]  bld_mask;
	logic [7:0]  r;
	logic [7:0]  res;
	logic [7:0]  hi;
	logic [7:0]  sreg_n;
	logic        wr_d;
	logic        wr_word;
	logic [aalu_pkg::BANK_AW-1:0] d_row;

	// Set Z, N, V and S from an 8-bit value and a given V
	function automatic logic [7:0] put_znsv(input logic [7:0] s, input logic [7:0] val,
			input logic v);
		logic [7:0] n;
		n = s;
		n[aalu_pkg::FLAG_Z] = (val == 8'h00);
		n[aalu_pkg::FLAG_N] = val[7];
		n[aalu_pkg::FLAG_V] = v;
		n[aalu_pkg::FLAG_S] = val[7] ^ v;
		return n;
	endfunction

	// Select operands from the bank read data
	assign d_row   = item.dest_index[aalu_pkg::REG_IDX_W-1:1];
	assign a       = item.dest_index[0] ? odd_a : even_a;
	assign src_reg = item.src_index[0] ? odd_b : even_b;
	assign src     = item.use_immediate ? item.immediate : src_reg;
	assign cin     = sreg[aalu_pkg::FLAG_C];
	assign add_cin = cin & (item.op == aalu_pkg::OP_ADC);
	assign sub_cin = cin & (item.op == aalu_pkg::OP_SBC || item.op == aalu_pkg::OP_CPC);

	// Byte adder and subtractor with their carry and overflow
	assign add_r = a + src + {7'd0, add_cin};
	assign sub_r = a - src - {7'd0, sub_cin};
	assign add_c = (a[7] & src[7]) | (src[7] & ~add_r[7]) | (~add_r[7] & a[7]);
	assign add_v = (a[7] & src[7] & ~add_r[7]) | (~a[7] & ~src[7] & add_r[7]);
	assign sub_c = (~a[7] & src[7]) | (src[7] & sub_r[7]) | (sub_r[7] & ~a[7]);
	assign sub_v = (a[7] & ~src[7] & ~sub_r[7]) | (~a[7] & src[7] & sub_r[7]);

	// Word adder and subtractor for the register pair
	assign word_in = {odd_a, even_a};
	assign word_k  = {10'd0, item.immediate[5:0]};
	assign word_r  = (item.op == aalu_pkg::OP_ADIW) ? word_in + word_k : word_in - word_k;

	assign bld_mask = 8'h01 << item.bit_index;

	// Decode the operation
	always_comb begin
		r       = 8'h00;
		res     = a;
		hi      = 8'h00;
		sreg_n  = sreg;
		wr_d    = 1'b0;
		wr_word = 1'b0;
		unique case (item.op)
			aalu_pkg::OP_ADD, aalu_pkg::OP_ADC: begin
				r      = add_r;
				sreg_n = put_znsv(sreg, add_r, add_v);
				sreg_n[aalu_pkg::FLAG_C] = add_c;
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_SUB, aalu_pkg::OP_SBC, aalu_pkg::OP_CP, aalu_pkg::OP_CPC: begin
				r      = sub_r;
				sreg_n = put_znsv(sreg, sub_r, sub_v);
				sreg_n[aalu_pkg::FLAG_C] = sub_c;
				if (item.op == aalu_pkg::OP_SBC || item.op == aalu_pkg::OP_CPC) begin
					sreg_n[aalu_pkg::FLAG_Z] = (sub_r == 8'h00) & sreg[aalu_pkg::FLAG_Z];
				end
				if (item.op == aalu_pkg::OP_SUB || item.op == aalu_pkg::OP_SBC) begin
					wr_d = 1'b1;
				end else begin
					res = sub_r;
				end
			end
			aalu_pkg::OP_AND: begin
				r      = a & src;
				sreg_n = put_znsv(sreg, a & src, 1'b0);
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_OR: begin
				r      = a | src;
				sreg_n = put_znsv(sreg, a | src, 1'b0);
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_EOR: begin
				r      = a ^ src;
				sreg_n = put_znsv(sreg, a ^ src, 1'b0);
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_COM: begin
				r      = ~a;
				sreg_n = put_znsv(sreg, ~a, 1'b0);
				sreg_n[aalu_pkg::FLAG_C] = 1'b1;
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_NEG: begin
				r      = 8'h00 - a;
				sreg_n = put_znsv(sreg, 8'h00 - a, (8'h00 - a) == 8'h80);
				sreg_n[aalu_pkg::FLAG_C] = (a != 8'h00);
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_INC: begin
				r      = a + 8'h01;
				sreg_n = put_znsv(sreg, a + 8'h01, a == 8'h7F);
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_DEC: begin
				r      = a - 8'h01;
				sreg_n = put_znsv(sreg, a - 8'h01, a == 8'h80);
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_LSR: begin
				r      = {1'b0, a[7:1]};
				sreg_n = put_znsv(sreg, {1'b0, a[7:1]}, a[0]);
				sreg_n[aalu_pkg::FLAG_C] = a[0];
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_ASR: begin
				r      = {a[7], a[7:1]};
				sreg_n = put_znsv(sreg, {a[7], a[7:1]}, a[7] ^ a[0]);
				sreg_n[aalu_pkg::FLAG_C] = a[0];
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_ROR: begin
				r      = {cin, a[7:1]};
				sreg_n = put_znsv(sreg, {cin, a[7:1]}, cin ^ a[0]);
				sreg_n[aalu_pkg::FLAG_C] = a[0];
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_LSL: begin
				r      = {a[6:0], 1'b0};
				sreg_n = put_znsv(sreg, {a[6:0], 1'b0}, a[6] ^ a[7]);
				sreg_n[aalu_pkg::FLAG_C] = a[7];
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_ROL: begin
				r      = {a[6:0], cin};
				sreg_n = put_znsv(sreg, {a[6:0], cin}, a[6] ^ a[7]);
				sreg_n[aalu_pkg::FLAG_C] = a[7];
				wr_d   = 1'b1;
			end
			aalu_pkg::OP_SWAP: begin
				r    = {a[3:0], a[7:4]};
				wr_d = 1'b1;
			end
			aalu_pkg::OP_MOV: begin
				r    = src_reg;
				wr_d = 1'b1;
			end
			aalu_pkg::OP_LDI: begin
				r    = item.immediate;
				wr_d = 1'b1;
			end
			aalu_pkg::OP_MOVW: begin
				res     = even_b;
				hi      = odd_b;
				wr_word = 1'b1;
			end
			aalu_pkg::OP_ADIW, aalu_pkg::OP_SBIW: begin
				res     = word_r[7:0];
				hi      = word_r[15:8];
				wr_word = 1'b1;
				if (item.op == aalu_pkg::OP_ADIW) begin
					sreg_n[aalu_pkg::FLAG_C] = ~word_r[15] & odd_a[7];
					sreg_n[aalu_pkg::FLAG_V] = ~odd_a[7] & word_r[15];
				end else begin
					sreg_n[aalu_pkg::FLAG_C] = word_r[15] & ~odd_a[7];
					sreg_n[aalu_pkg::FLAG_V] = odd_a[7] & ~word_r[15];
				end
				sreg_n[aalu_pkg::FLAG_Z] = (word_r == 16'h0000);
				sreg_n[aalu_pkg::FLAG_N] = word_r[15];
				sreg_n[aalu_pkg::FLAG_S] = word_r[15] ^ sreg_n[aalu_pkg::FLAG_V];
			end
			aalu_pkg::OP_BSET: begin
				sreg_n[item.bit_index] = 1'b1;
			end
			aalu_pkg::OP_BCLR: begin
				sreg_n[item.bit_index] = 1'b0;
			end
			aalu_pkg::OP_BLD: begin
				r    = sreg[aalu_pkg::FLAG_T] ? (a | bld_mask) : (a & ~bld_mask);
				wr_d = 1'b1;
			end
			aalu_pkg::OP_BST: begin
				sreg_n[aalu_pkg::FLAG_T] = a[item.bit_index];
			end
			aalu_pkg::OP_TST: begin
				sreg_n = put_znsv(sreg, a, 1'b0);
			end
			default: begin
				sreg_n = sreg;
			end
		endcase
		if (wr_d) begin
			res = r;
		end
	end

	// Plan the bank writes
	always_comb begin
		exec.rsp.result      = res;
		exec.rsp.result_high = hi;
		exec.rsp.status      = sreg_n;
		exec.even_wr.en      = (wr_d & ~item.dest_index[0]) | wr_word;
		exec.even_wr.addr    = d_row;
		exec.even_wr.data    = wr_word ? res : r;
		exec.odd_wr.en       = (wr_d & item.dest_index[0]) | wr_word;
		exec.odd_wr.addr     = d_row;
		exec.odd_wr.data     = wr_word ? hi : r;
	end

endmodule

// ===== hw/rtl/aalu_outq.sv =====
// Two-entry result queue that decouples write-back from the receiver.
module aalu_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  aalu_pkg::rsp_t     push_item,
	output logic               full,
	aalu_rsp_if.source         rsp
);

	aalu_pkg::rsp_t slot_q [2];
	logic [1:0]     count_q;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic           pop;

	assign pop  = rsp.valid & rsp.ready;
	assign full = (count_q == 2'd2);

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Present the oldest item
	assign rsp.valid       = (count_q != 2'd0);
	assign rsp.result      = slot_q[rd_ptr_q].result;
	assign rsp.result_high = slot_q[rd_ptr_q].result_high;
	assign rsp.status      = slot_q[rd_ptr_q].status;

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result queue pushed while full");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");
`endif

endmodule

// ===== hw/rtl/avr_alu_with_status_flags_core.sv =====
// AVR-style 8-bit ALU with banked register file and status register.
//
// Usage:
//   cmd carries one decoded instruction per item (op, dest_index, src_index,
//   use_immediate, immediate, bit_index); rsp returns one item per
//   instruction with the destination value, the pair high byte and SREG.
//   Both channels move an item when valid and ready are high at a clock edge.
// Timing and throughput:
//   An item accepted at an edge reads the register banks at that edge, is
//   executed from the registered data and written back when it commits, and
//   shows on rsp right after it. One item per cycle is sustained while the
//   result queue is not full, dependent instructions included; write-first
//   forwarding on each bank read port lets the banks sustain that rate.
// Reset:
//   arst_n clears SREG and the per-entry valid bits of the register banks,
//   so every register reads as zero until written; no clearing pass is run.
// Receiver stall:
//   A two-entry result queue absorbs results; when it is full the executing
//   item holds and cmd.ready drops until the receiver takes a result.
module avr_alu_with_status_flags_core (
	input  logic        clk,
	input  logic        arst_n,
	aalu_cmd_if.sink    cmd,
	aalu_rsp_if.source  rsp
);

	logic               fire;
	logic               commit;
	logic               q_full;
	logic               s1_valid_q;
	aalu_pkg::cmd_t     item_s1;
	logic [7:0]         sreg_q;
	logic [7:0]         even_a;
	logic [7:0]         even_b;
	logic [7:0]         odd_a;
	logic [7:0]         odd_b;
	aalu_pkg::exec_t    exec;
	aalu_pkg::bank_wr_t even_wr;
	aalu_pkg::bank_wr_t odd_wr;

	// Handshake: take a new item whenever the execute stage frees up
	assign commit    = s1_valid_q & ~q_full;
	assign cmd.ready = ~s1_valid_q | commit;
	assign fire      = cmd.valid & cmd.ready;

	// Execute stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= cmd.valid;
		end
	end

	// Execute stage payload
	always_ff @(posedge clk) begin
		if (fire) begin
			item_s1.op            <= cmd.op;
			item_s1.dest_index    <= cmd.dest_index;
			item_s1.src_index     <= cmd.src_index;
			item_s1.use_immediate <= cmd.use_immediate;
			item_s1.immediate     <= cmd.immediate;
			item_s1.bit_index     <= cmd.bit_index;
		end
	end

	// Status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sreg_q <= 8'h00;
		end else if (commit) begin
			sreg_q <= exec.rsp.status;
		end
	end

	// Gate write-back with commit
	always_comb begin
		even_wr    = exec.even_wr;
		even_wr.en = exec.even_wr.en & commit;
		odd_wr     = exec.odd_wr;
		odd_wr.en  = exec.odd_wr.en & commit;
	end

	aalu_bank u_even_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (fire),
		.rd_addr_a (cmd.dest_index[aalu_pkg::REG_IDX_W-1:1]),
		.rd_addr_b (cmd.src_index[aalu_pkg::REG_IDX_W-1:1]),
		.wr        (even_wr),
		.rd_data_a (even_a),
		.rd_data_b (even_b)
	);

	aalu_bank u_odd_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (fire),
		.rd_addr_a (cmd.dest_index[aalu_pkg::REG_IDX_W-1:1]),
		.rd_addr_b (cmd.src_index[aalu_pkg::REG_IDX_W-1:1]),
		.wr        (odd_wr),
		.rd_data_a (odd_a),
		.rd_data_b (odd_b)
	);

	aalu_exec u_exec (
		.item   (item_s1),
		.even_a (even_a),
		.even_b (even_b),
		.odd_a  (odd_a),
		.odd_b  (odd_b),
		.sreg   (sreg_q),
		.exec   (exec)
	);

	aalu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (commit),
		.push_item (exec.rsp),
		.full      (q_full),
		.rsp       (rsp)
	);

`ifndef ASSERT_OFF
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !commit |=> s1_valid_q)
		else $error("stalled instruction dropped from execute stage");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp.valid)
		else $error("committed instruction produced no result");
	a_word_pair: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (item_s1.op == aalu_pkg::OP_MOVW || item_s1.op == aalu_pkg::OP_ADIW ||
			item_s1.op == aalu_pkg::OP_SBIW) |-> even_wr.en && odd_wr.en &&
			even_wr.addr == odd_wr.addr)
		else $error("word operation did not write both halves of the pair");
`endif

endmodule

// ===== bench/tb_avr_alu_with_status_flags_core.sv =====
// Self-checking bench for the AVR-style ALU: random and directed instructions against a predictor.
module tb_avr_alu_with_status_flags_core;
	import aalu_pkg::*;

	localparam int unsigned ITEM_COUNT  = 1700;
	localparam int unsigned IDLE_PCT    = 31;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [4:0]  OP_UNUSED_FIRST = 5'd29;
	localparam logic [4:0]  OP_UNUSED_LAST  = 5'd31;

	logic clk;
	logic arst_n;

	aalu_cmd_if cmd_ch ();
	aalu_rsp_if rsp_ch ();

	avr_alu_with_status_flags_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Predictor state: register file and SREG as the block should hold them
	logic [7:0] gpr [NUM_REGS];
	logic [7:0] sreg;

	cmd_t  instr_q [$];
	rsp_t  expected_q [$];
	cmd_t  next_instr;
	logic  cmd_fired;
	logic  calm;
	int unsigned n_total;
	int unsigned n_taken;
	int unsigned n_errors;
	int unsigned cycle_count;

	// Hold a long stretch with no idling on either side
	assign calm = (n_taken >= 700) && (n_taken < 1000);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Update Z, N, V and S from an 8-bit result
	function automatic void put_znsv(logic [7:0] r, logic v);
		sreg[FLAG_Z] = (r == 8'h00);
		sreg[FLAG_N] = r[7];
		sreg[FLAG_V] = v;
		sreg[FLAG_S] = r[7] ^ v;
	endfunction

	function automatic logic [7:0] add_bytes(logic [7:0] a, logic [7:0] b, logic cin);
		logic [7:0] r;
		r = a + b + cin;
		sreg[FLAG_C] = (a[7] & b[7]) | (b[7] & ~r[7]) | (~r[7] & a[7]);
		put_znsv(r, (a[7] & b[7] & ~r[7]) | (~a[7] & ~b[7] & r[7]));
		return r;
	endfunction

	// Subtract; in carry chains Z only stays set if it was set before
	function automatic logic [7:0] sub_bytes(logic [7:0] a, logic [7:0] b, logic cin,
			logic chain);
		logic [7:0] r;
		logic       z_prev;
		z_prev = sreg[FLAG_Z];
		r = a - b - cin;
		sreg[FLAG_C] = (~a[7] & b[7]) | (b[7] & r[7]) | (r[7] & ~a[7]);
		put_znsv(r, (a[7] & ~b[7] & ~r[7]) | (~a[7] & b[7] & r[7]));
		if (chain) begin
			sreg[FLAG_Z] = (r == 8'h00) && z_prev;
		end
		return r;
	endfunction

	function automatic void shift_flags(logic [7:0] r, logic c);
		sreg[FLAG_C] = c;
		put_znsv(r, r[7] ^ c);
	endfunction

	// Execute one instruction on the predictor state and return the result item
	function automatic rsp_t execute_instr(cmd_t c);
		int unsigned d, s, dl, dh, sl, sh;
		logic [7:0]  a, opnd, r, res, hi, lo_byte, hi_byte;
		logic        cin, wr_d, h7, r15;
		logic [15:0] w, w_new;
		d    = c.dest_index % NUM_REGS;
		s    = c.src_index % NUM_REGS;
		dl   = {c.dest_index[4:1], 1'b0} % NUM_REGS;
		dh   = ({c.dest_index[4:1], 1'b0} + 1) % NUM_REGS;
		sl   = {c.src_index[4:1], 1'b0} % NUM_REGS;
		sh   = ({c.src_index[4:1], 1'b0} + 1) % NUM_REGS;
		a    = gpr[d];
		opnd = c.use_immediate ? c.immediate : gpr[s];
		cin  = sreg[FLAG_C];
		res  = a;
		hi   = 8'h00;
		r    = 8'h00;
		wr_d = 1'b0;
		case (c.op)
			OP_ADD: begin r = add_bytes(a, opnd, 1'b0); wr_d = 1'b1; end
			OP_ADC: begin r = add_bytes(a, opnd, cin); wr_d = 1'b1; end
			OP_SUB: begin r = sub_bytes(a, opnd, 1'b0, 1'b0); wr_d = 1'b1; end
			OP_SBC: begin r = sub_bytes(a, opnd, cin, 1'b1); wr_d = 1'b1; end
			OP_AND: begin r = a & opnd; put_znsv(r, 1'b0); wr_d = 1'b1; end
			OP_OR: begin r = a | opnd; put_znsv(r, 1'b0); wr_d = 1'b1; end
			OP_EOR: begin r = a ^ opnd; put_znsv(r, 1'b0); wr_d = 1'b1; end
			OP_CP: res = sub_bytes(a, opnd, 1'b0, 1'b0);
			OP_CPC: res = sub_bytes(a, opnd, cin, 1'b1);
			OP_COM: begin
				r = ~a;
				sreg[FLAG_C] = 1'b1;
				put_znsv(r, 1'b0);
				wr_d = 1'b1;
			end
			OP_NEG: begin
				r = 8'h00 - a;
				sreg[FLAG_C] = (r != 8'h00);
				put_znsv(r, r == 8'h80);
				wr_d = 1'b1;
			end
			OP_INC: begin r = a + 8'h01; put_znsv(r, r == 8'h80); wr_d = 1'b1; end
			OP_DEC: begin r = a - 8'h01; put_znsv(r, r == 8'h7F); wr_d = 1'b1; end
			OP_LSR: begin r = {1'b0, a[7:1]}; shift_flags(r, a[0]); wr_d = 1'b1; end
			OP_ASR: begin r = {a[7], a[7:1]}; shift_flags(r, a[0]); wr_d = 1'b1; end
			OP_ROR: begin r = {cin, a[7:1]}; shift_flags(r, a[0]); wr_d = 1'b1; end
			OP_LSL: begin r = {a[6:0], 1'b0}; shift_flags(r, a[7]); wr_d = 1'b1; end
			OP_ROL: begin r = {a[6:0], cin}; shift_flags(r, a[7]); wr_d = 1'b1; end
			OP_SWAP: begin r = {a[3:0], a[7:4]}; wr_d = 1'b1; end
			OP_MOV: begin r = gpr[s]; wr_d = 1'b1; end
			OP_MOVW: begin
				lo_byte = gpr[sl];
				hi_byte = gpr[sh];
				gpr[dl] = lo_byte;
				gpr[dh] = hi_byte;
				res = gpr[dl];
				hi  = gpr[dh];
			end
			OP_LDI: begin r = c.immediate; wr_d = 1'b1; end
			OP_ADIW, OP_SBIW: begin
				h7 = gpr[dh][7];
				w  = {gpr[dh], gpr[dl]};
				if (c.op == OP_ADIW) begin
					w_new = w + {10'd0, c.immediate[5:0]};
				end else begin
					w_new = w - {10'd0, c.immediate[5:0]};
				end
				r15 = w_new[15];
				if (c.op == OP_ADIW) begin
					sreg[FLAG_C] = ~r15 & h7;
					sreg[FLAG_V] = ~h7 & r15;
				end else begin
					sreg[FLAG_C] = r15 & ~h7;
					sreg[FLAG_V] = h7 & ~r15;
				end
				sreg[FLAG_Z] = (w_new == 16'h0000);
				sreg[FLAG_N] = r15;
				sreg[FLAG_S] = r15 ^ sreg[FLAG_V];
				gpr[dl] = w_new[7:0];
				gpr[dh] = w_new[15:8];
				res = gpr[dl];
				hi  = gpr[dh];
			end
			OP_BSET: sreg[c.bit_index] = 1'b1;
			OP_BCLR: sreg[c.bit_index] = 1'b0;
			OP_BLD: begin
				if (sreg[FLAG_T]) begin
					r = a | (8'h01 << c.bit_index);
				end else begin
					r = a & ~(8'h01 << c.bit_index);
				end
				wr_d = 1'b1;
			end
			OP_BST: sreg[FLAG_T] = a[c.bit_index];
			OP_TST: put_znsv(a, 1'b0);
			default: ;
		endcase
		if (wr_d) begin
			gpr[d] = r;
			res = r;
		end
		return {res, hi, sreg};
	endfunction

	task automatic push_instr(logic [4:0] op, logic [4:0] d, logic [4:0] s, logic ui,
			logic [7:0] k, logic [2:0] b);
		instr_q.push_back({op, d, s, ui, k, b});
		n_total++;
	endtask

	// Favor the corner values of a byte
	function automatic logic [7:0] pick_byte();
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 30) begin
			case ($urandom_range(0, 4))
				0: v = 8'h00;
				1: v = 8'hFF;
				2: v = 8'h7F;
				3: v = 8'h80;
				default: v = 8'h01;
			endcase
		end
		return v;
	endfunction

	// Queue directed instructions, then random ones
	task automatic build_stimulus();
		int unsigned pick, len, kind, d0, s0;
		logic [4:0]  first_op, carry_op, op;
		logic        ui;
		// directed: corners of each operation
		push_instr(OP_LDI, 5'd16, 5'd0, 1'b0, 8'hFF, 3'd0);
		push_instr(OP_LDI, 5'd17, 5'd0, 1'b0, 8'h80, 3'd0);
		push_instr(OP_ADD, 5'd16, 5'd17, 1'b0, 8'h00, 3'd0);
		push_instr(OP_ADC, 5'd17, 5'd0, 1'b1, 8'hFF, 3'd0);
		push_instr(OP_SUB, 5'd16, 5'd16, 1'b0, 8'h00, 3'd0);
		push_instr(OP_SBC, 5'd17, 5'd16, 1'b0, 8'h00, 3'd0);
		push_instr(OP_CP, 5'd17, 5'd0, 1'b1, 8'h80, 3'd0);
		push_instr(OP_CPC, 5'd16, 5'd0, 1'b1, 8'h00, 3'd0);
		push_instr(OP_AND, 5'd17, 5'd16, 1'b0, 8'h00, 3'd0);
		push_instr(OP_OR, 5'd16, 5'd0, 1'b1, 8'hFF, 3'd0);
		push_instr(OP_EOR, 5'd16, 5'd17, 1'b0, 8'h00, 3'd0);
		push_instr(OP_COM, 5'd0, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_LDI, 5'd1, 5'd0, 1'b0, 8'h80, 3'd0);
		push_instr(OP_NEG, 5'd1, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_NEG, 5'd2, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_LDI, 5'd3, 5'd0, 1'b0, 8'h7F, 3'd0);
		push_instr(OP_INC, 5'd3, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_DEC, 5'd3, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_LSR, 5'd0, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_ASR, 5'd1, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_ROR, 5'd16, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_LSL, 5'd17, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_ROL, 5'd3, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_SWAP, 5'd16, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_MOV, 5'd31, 5'd16, 1'b1, 8'h55, 3'd0);
		push_instr(OP_MOVW, 5'd25, 5'd31, 1'b0, 8'h00, 3'd0);
		push_instr(OP_ADIW, 5'd25, 5'd0, 1'b0, 8'hFF, 3'd0);
		push_instr(OP_SBIW, 5'd4, 5'd0, 1'b0, 8'h01, 3'd0);
		push_instr(OP_BSET, 5'd0, 5'd0, 1'b1, 8'h00, 3'd7);
		push_instr(OP_BCLR, 5'd0, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_BST, 5'd16, 5'd0, 1'b0, 8'h00, 3'd7);
		push_instr(OP_BLD, 5'd5, 5'd0, 1'b0, 8'h00, 3'd3);
		push_instr(OP_TST, 5'd2, 5'd0, 1'b0, 8'h00, 3'd0);
		push_instr(OP_UNUSED_LAST, 5'd16, 5'd17, 1'b1, 8'hAA, 3'd5);

		// random: single instructions, multi-byte carry chains, word ops
		while (n_total < ITEM_COUNT) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if ($urandom_range(0, 99) < 3) begin
					op = 5'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
				end else begin
					op = 5'($urandom_range(OP_ADD, OP_TST));
				end
				push_instr(op, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)), pick_byte(), 3'($urandom_range(0, 7)));
			end else if (pick < 85) begin
				len  = $urandom_range(2, 4);
				kind = $urandom_range(0, 2);
				d0   = $urandom_range(0, 31);
				s0   = $urandom_range(0, 31);
				case (kind)
					0: begin first_op = OP_ADD; carry_op = OP_ADC; end
					1: begin first_op = OP_SUB; carry_op = OP_SBC; end
					default: begin first_op = OP_CP; carry_op = OP_CPC; end
				endcase
				if ($urandom_range(0, 1) == 1) begin
					for (int unsigned i = 0; i < len; i++) begin
						push_instr(OP_LDI, 5'((d0 + i) % 32), 5'd0, 1'b0, pick_byte(), 3'd0);
					end
				end
				for (int unsigned i = 0; i < len; i++) begin
					ui = ($urandom_range(0, 99) < 30);
					push_instr((i == 0) ? first_op : carry_op, 5'((d0 + i) % 32),
						5'((s0 + i) % 32), ui, pick_byte(), 3'($urandom_range(0, 7)));
				end
			end else begin
				d0 = $urandom_range(0, 31);
				push_instr(OP_LDI, {d0[4:1], 1'b0}, 5'd0, 1'b0, pick_byte(), 3'd0);
				push_instr(OP_LDI, {d0[4:1], 1'b1}, 5'd0, 1'b0, pick_byte(), 3'd0);
				case ($urandom_range(0, 2))
					0: op = OP_ADIW;
					1: op = OP_SBIW;
					default: op = OP_MOVW;
				endcase
				push_instr(op, 5'(d0), 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
					pick_byte(), 3'($urandom_range(0, 7)));
			end
		end
	endtask

	// Drive instructions and receiver readiness at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (!cmd_ch.valid || cmd_fired) begin
				if (instr_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_instr = instr_q.pop_front();
					cmd_ch.op            <= next_instr.op;
					cmd_ch.dest_index    <= next_instr.dest_index;
					cmd_ch.src_index     <= next_instr.src_index;
					cmd_ch.use_immediate <= next_instr.use_immediate;
					cmd_ch.immediate     <= next_instr.immediate;
					cmd_ch.bit_index     <= next_instr.bit_index;
					cmd_ch.valid         <= 1'b1;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Predict on each accepted item and check each accepted result
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_fired <= 1'b0;
		end else begin
			cmd_fired <= cmd_ch.valid && cmd_ch.ready;
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_q.push_back(execute_instr({cmd_ch.op, cmd_ch.dest_index,
					cmd_ch.src_index, cmd_ch.use_immediate, cmd_ch.immediate,
					cmd_ch.bit_index}));
				n_taken++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result item: result %02h result_high %02h status %02h",
						rsp_ch.result, rsp_ch.result_high, rsp_ch.status);
					n_errors++;
				end else begin
					rsp_t want;
					want = expected_q.pop_front();
					if (rsp_ch.result !== want.result) begin
						$error("result: expected %02h, got %02h", want.result, rsp_ch.result);
						n_errors++;
					end
					if (rsp_ch.result_high !== want.result_high) begin
						$error("result_high: expected %02h, got %02h", want.result_high,
							rsp_ch.result_high);
						n_errors++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %02h, got %02h", want.status, rsp_ch.status);
						n_errors++;
					end
				end
			end
		end
	end

	// Abort a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("avr_alu_with_status_flags_core: mismatch");
		$finish;
	end

	// Reset, run the stimulus and report
	initial begin
		arst_n               = 1'b0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.op            = OP_ADD;
		cmd_ch.dest_index    = 5'd0;
		cmd_ch.src_index     = 5'd0;
		cmd_ch.use_immediate = 1'b0;
		cmd_ch.immediate     = 8'h00;
		cmd_ch.bit_index     = 3'd0;
		rsp_ch.ready         = 1'b0;
		cmd_fired            = 1'b0;
		n_total              = 0;
		n_taken              = 0;
		n_errors             = 0;
		sreg                 = 8'h00;
		for (int unsigned i = 0; i < NUM_REGS; i++) begin
			gpr[i] = 8'h00;
		end
		build_stimulus();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (n_taken < n_total || expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (n_errors == 0 && expected_q.size() == 0) begin
			$display("avr_alu_with_status_flags_core: match");
		end else begin
			$display("avr_alu_with_status_flags_core: mismatch");
		end
		$finish;
	end

endmodule
